>>> hdl/log_frame_checker_macros.svh
// assertion macros shared by the log frame checker modules
`ifndef LOG_FRAME_CHECKER_MACROS_SVH
`define LOG_FRAME_CHECKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define LFC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfc assertion failed");
// next-cycle implication, disabled while in reset
`define LFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfc assertion failed");
`else
`define LFC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hdl/lfc_pkg.sv
package lfc_pkg;

  localparam int PACKET_BYTES  = 25;
  localparam int HEADER_BYTES  = 12;
  localparam int TRAILER_BYTES = 4;
  localparam int SEEN_W        = 40;
  localparam int OFFSET_W      = 5;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] FNV_START = 32'h811C_9DC5;
  localparam logic [31:0] FNV_MULT  = 32'h0100_0193;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_SHORT,
    STAT_BAD_SUM,
    STAT_BAD_HDR,
    STAT_BAD_LEN
  } status_t;

  // where the byte leaving the delay line lands
  typedef enum logic [1:0] {
    CLS_MAGIC,
    CLS_VERSION,
    CLS_COUNT,
    CLS_PAYLOAD
  } byte_class_t;

  // one request from the front to the back
  typedef struct packed {
    logic              hash_en;
    byte_class_t       cls;
    logic [1:0]        idx;
    logic [7:0]        data;
    logic              last;
    logic              too_short;
    logic [SEEN_W-1:0] len_m4;
    logic [31:0]       trailer;
  } job_t;

  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h49; // I
      2'd1:    c = 8'h53; // S
      2'd2:    c = 8'h43; // C
      default: c = 8'h4C; // L
    endcase
    return c;
  endfunction

endpackage

>>> hdl/log_frame_checker.sv
// Checks a command log that arrives one byte per request on the slave side, with tlast on
// the final byte. The last four bytes of a log are its little-endian FNV-1a 32 checksum, so
// a four-byte delay line holds them back; every byte that leaves the delay line is hashed.
// The first 12 hashed bytes are the header: magic "ISCL", a little-endian version word that
// must be 1, and a little-endian packet count. Every later byte goes out at once as a
// provisional packet byte (tuser 0) tagged with its packet number and its offset inside a
// 25-byte packet. After the final byte one status request follows (tuser 1, tlast 1):
// 0 ok, 1 shorter than 16 bytes, 2 checksum mismatch, 3 bad magic or version, 4 length
// before the checksum not 12 + count * 25, checked in that order. A consumer must drop the
// packet bytes of a log whose status is not ok. The front takes one byte per cycle while the
// queue has room and hands requests to the back through a four-entry queue; the back hashes
// one byte per cycle (one constant 32-bit multiply) while its output register is free, so
// the sustained rate is one byte per clock while m_tready holds; a status state follows each
// log. The byte counter saturates at 2^40-1 and the packet number wraps at 2^32.
module log_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // packet_byte, packet_number, byte_offset, status
  output logic [0:0]  m_tuser,   // kind
  output logic        m_tlast    // run_end
);
  import lfc_pkg::*;

  // front to queue
  logic push;
  logic push_ready;
  job_t push_job;

  // queue to back
  logic q_valid;
  logic q_ready;
  job_t q_job;

  lfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push       (push),
    .push_ready (push_ready),
    .job        (push_job)
  );

  // decouples byte intake from hashing and result delivery
  lfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (push_ready),
    .in_job    (push_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  lfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_job    (q_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser[0]),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hdl/lfc_front.sv
`include "log_frame_checker_macros.svh"

module lfc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tlast,
  output logic          push,
  input  logic          push_ready,
  output lfc_pkg::job_t job
);
  import lfc_pkg::*;

  logic [7:0]        delay [TRAILER_BYTES];
  logic [SEEN_W-1:0] bytes_seen;
  logic [SEEN_W-1:0] len;
  logic              accept;

  assign s_tready = push_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    len = (bytes_seen == SEEN_MAX) ? bytes_seen : bytes_seen + SEEN_W'(1);
    job.hash_en = (bytes_seen >= SEEN_W'(TRAILER_BYTES));
    if (bytes_seen < SEEN_W'(TRAILER_BYTES + 4)) begin
      job.cls = CLS_MAGIC;
    end else if (bytes_seen < SEEN_W'(TRAILER_BYTES + 8)) begin
      job.cls = CLS_VERSION;
    end else if (bytes_seen < SEEN_W'(TRAILER_BYTES + HEADER_BYTES)) begin
      job.cls = CLS_COUNT;
    end else begin
      job.cls = CLS_PAYLOAD;
    end
    job.idx       = bytes_seen[1:0];
    job.data      = delay[0];
    job.last      = s_tlast;
    job.too_short = (len < SEEN_W'(HEADER_BYTES + TRAILER_BYTES));
    job.len_m4    = len - SEEN_W'(TRAILER_BYTES);
    job.trailer   = {s_tdata, delay[3], delay[2], delay[1]};
  end

  // bytes still inside the delay line need no request
  assign push = accept && (job.hash_en || s_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      for (int i = 0; i < TRAILER_BYTES; i++) delay[i] <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen <= '0;
        for (int i = 0; i < TRAILER_BYTES; i++) delay[i] <= '0;
      end else begin
        bytes_seen <= len;
        for (int i = 0; i < TRAILER_BYTES - 1; i++) delay[i] <= delay[i+1];
        delay[TRAILER_BYTES-1] <= s_tdata;
      end
    end
  end

  `LFC_ASSERT_NEXT(a_front_restart, clk, rst, accept && s_tlast, bytes_seen == '0)

endmodule

>>> hdl/lfc_queue.sv
`include "log_frame_checker_macros.svh"

module lfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lfc_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output lfc_pkg::job_t out_job
);
  import lfc_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `LFC_ASSERT_NEXT(a_queue_drain, clk, rst, pop && !push, count + QCNT_W'(1) == $past(count))
  `LFC_ASSERT_IMPL(a_queue_bound, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))

endmodule

>>> hdl/lfc_back.sv
`include "log_frame_checker_macros.svh"

module lfc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  lfc_pkg::job_t q_job,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [47:0]   m_tdata,
  output logic          m_tuser,
  output logic          m_tlast
);
  import lfc_pkg::*;

  typedef enum logic {ST_RUN, ST_STATUS} state_t;

  state_t              state;
  logic [31:0]         running_hash;
  logic                magic_ok;
  logic [31:0]         version_word;
  logic [31:0]         packet_total;
  logic [OFFSET_W-1:0] offset_in_packet;
  logic [31:0]         packet_counter;
  logic                saved_short;
  logic [SEEN_W-1:0]   saved_len_m4;
  logic [31:0]         saved_trailer;

  logic                needs_out;
  logic                out_free;
  logic                pop;
  logic                status_load;
  logic                out_load;
  logic [31:0]         hash_next;
  logic [OFFSET_W:0]   offset_inc;
  logic [SEEN_W-1:0]   want;
  status_t             stat;

  always_comb begin
    needs_out   = q_job.hash_en && (q_job.cls == CLS_PAYLOAD);
    out_free    = !m_tvalid || m_tready;
    pop         = (state == ST_RUN) && q_valid && (!needs_out || out_free);
    status_load = (state == ST_STATUS) && out_free;
    // output register takes a packet byte or the status
    out_load    = (pop && needs_out) || status_load;
    hash_next   = (running_hash ^ {24'd0, q_job.data}) * FNV_MULT;
    offset_inc  = {1'b0, offset_in_packet} + (OFFSET_W+1)'(1);
    want = SEEN_W'(HEADER_BYTES) + {8'd0, packet_total} * SEEN_W'(PACKET_BYTES);
    if (saved_short) begin
      stat = STAT_SHORT;
    end else if (running_hash != saved_trailer) begin
      stat = STAT_BAD_SUM;
    end else if (!magic_ok || version_word != 32'd1) begin
      stat = STAT_BAD_HDR;
    end else if (saved_len_m4 != want) begin
      stat = STAT_BAD_LEN;
    end else begin
      stat = STAT_OK;
    end
  end

  assign q_ready = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_RUN;
      m_tvalid         <= 1'b0;
      running_hash     <= FNV_START;
      magic_ok         <= 1'b1;
      version_word     <= '0;
      packet_total     <= '0;
      offset_in_packet <= '0;
      packet_counter   <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (pop) begin
            if (q_job.hash_en) begin
              running_hash <= hash_next;
              unique case (q_job.cls)
                CLS_MAGIC: begin
                  if (q_job.data != magic_char(q_job.idx)) magic_ok <= 1'b0;
                end
                CLS_VERSION: version_word[{q_job.idx, 3'b000} +: 8] <= q_job.data;
                CLS_COUNT:   packet_total[{q_job.idx, 3'b000} +: 8] <= q_job.data;
                CLS_PAYLOAD: begin
                  m_tuser  <= KIND_PACKET;
                  m_tlast  <= 1'b0;
                  m_tdata  <= {STAT_OK, offset_in_packet, packet_counter, q_job.data};
                  if (offset_inc >= (OFFSET_W+1)'(PACKET_BYTES)) begin
                    offset_in_packet <= '0;
                    packet_counter   <= packet_counter + 32'd1;
                  end else begin
                    offset_in_packet <= offset_inc[OFFSET_W-1:0];
                  end
                end
              endcase
            end
            if (q_job.last) begin
              state         <= ST_STATUS;
              saved_short   <= q_job.too_short;
              saved_len_m4  <= q_job.len_m4;
              saved_trailer <= q_job.trailer;
            end
          end
        end
        ST_STATUS: begin
          if (status_load) begin
            m_tuser          <= KIND_STATUS;
            m_tlast          <= 1'b1;
            m_tdata          <= {stat, {OFFSET_W{1'b0}}, 32'd0, 8'd0};
            state            <= ST_RUN;
            running_hash     <= FNV_START;
            magic_ok         <= 1'b1;
            version_word     <= '0;
            packet_total     <= '0;
            offset_in_packet <= '0;
            packet_counter   <= '0;
          end
        end
      endcase
    end
  end

  `LFC_ASSERT_IMPL(a_back_hold, clk, rst, state == ST_STATUS, !pop)
  `LFC_ASSERT_NEXT(a_back_end, clk, rst, pop && q_job.last, state == ST_STATUS)
  `LFC_ASSERT_NEXT(a_back_clear, clk, rst, status_load, packet_counter == 32'd0 && offset_in_packet == '0 && magic_ok)

endmodule
